[rtl/core/ddob_pkg.sv]
// ----------------------------------------------------------------------------
// ddob_pkg
// shared types, codes and constant tables of the obstacle backoff core
// ----------------------------------------------------------------------------
package ddob_pkg;

  // shared multiplier operand width, wide enough for every product in the
  // frac range 8..24
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;
  localparam int POS_W  = 28;
  localparam int ITER_W = 5;
  localparam int ATAN_N = 24;

  localparam logic signed [POS_W-1:0] POS_MAX = 28'sd134217727;
  localparam logic signed [POS_W-1:0] POS_MIN = -28'sd134217728;

  // atan(2^-i) as a fraction of a 32 bit turn
  localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  // 65536 / (2 pi) in q8
  localparam logic [21:0]        BRAD_PER_RAD = 22'd2670177;

  // register reset values
  localparam logic [7:0]  RST_MIN_SPEED    = 8'd40;
  localparam logic [7:0]  RST_MAX_SPEED    = 8'd80;
  localparam logic [10:0] RST_OBST_DIST    = 11'd100;
  localparam logic [23:0] RST_BACKOFF_TIME = 24'd327680;
  localparam logic [15:0] RST_INV_WBASE    = 16'd1638;
  localparam logic [11:0] RST_START_X      = 12'd200;
  localparam logic [11:0] RST_START_Y      = 12'd200;

  typedef enum logic [2:0] {
    CFG_MIN_SPEED     = 3'd0,
    CFG_MAX_SPEED     = 3'd1,
    CFG_OBST_DIST     = 3'd2,
    CFG_BACKOFF_TIME  = 3'd3,
    CFG_INV_WBASE     = 3'd4,
    CFG_START_X       = 3'd5,
    CFG_START_Y       = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_NEAR,
    OP_DEC,
    OP_CORD,
    OP_VDT,
    OP_WDT,
    OP_UMUL,
    OP_MX,
    OP_MY,
    OP_HLO,
    OP_HHI,
    OP_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic point_valid;
    logic end_of_frame;
    logic cordic_last;
    logic out_full;
  } dp_status_t;

endpackage

[rtl/core/ddob_ctrl.sv]
// ----------------------------------------------------------------------------
// ddob_ctrl
// sequencer that walks the datapath through one item's operations
// ----------------------------------------------------------------------------
module ddob_ctrl import ddob_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DIFF = 15'b000000000000010,
    S_SQX  = 15'b000000000000100,
    S_SQY  = 15'b000000000001000,
    S_NEAR = 15'b000000000010000,
    S_DEC  = 15'b000000000100000,
    S_CORD = 15'b000000001000000,
    S_VDT  = 15'b000000010000000,
    S_WDT  = 15'b000000100000000,
    S_UMUL = 15'b000001000000000,
    S_MX   = 15'b000010000000000,
    S_MY   = 15'b000100000000000,
    S_HLO  = 15'b001000000000000,
    S_HHI  = 15'b010000000000000,
    S_UPD  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        if (status.point_valid) begin
          cmd.op     = OP_DIFF;
          state_next = S_SQX;
        end else if (status.end_of_frame) begin
          state_next = S_DEC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_NEAR;
      end
      S_NEAR: begin
        cmd.op     = OP_NEAR;
        state_next = status.end_of_frame ? S_DEC : S_IDLE;
      end
      S_DEC: begin
        cmd.op     = OP_DEC;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.op = OP_CORD;
        if (status.cordic_last) state_next = S_VDT;
      end
      S_VDT: begin
        cmd.op     = OP_VDT;
        state_next = S_WDT;
      end
      S_WDT: begin
        cmd.op     = OP_WDT;
        state_next = S_UMUL;
      end
      S_UMUL: begin
        cmd.op     = OP_UMUL;
        state_next = S_MX;
      end
      S_MX: begin
        cmd.op     = OP_MX;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.op     = OP_MY;
        state_next = S_HLO;
      end
      S_HLO: begin
        cmd.op     = OP_HLO;
        state_next = S_HHI;
      end
      S_HHI: begin
        cmd.op     = OP_HHI;
        state_next = S_UPD;
      end
      S_UPD: begin
        // wait here while the previous result is still held
        if (!status.out_full) begin
          cmd.op     = OP_UPD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/ddob_datapath.sv]
// ----------------------------------------------------------------------------
// ddob_datapath
// registers, shared multiplier, cordic and pose update of the backoff core
// ----------------------------------------------------------------------------
module ddob_datapath import ddob_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS         = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  input  logic                    point_valid,
  input  logic [11:0]             point_x,
  input  logic [11:0]             point_y,
  input  logic                    end_of_frame,
  input  logic [15:0]             step_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] position_x_out,
  output logic signed [POS_W-1:0] position_y_out,
  output logic [15:0]             heading_out,
  output logic signed [8:0]       left_speed_out,
  output logic signed [8:0]       right_speed_out,
  output logic                    backing_up,
  output logic signed [24:0]      countdown_out
);

  localparam int RS    = 30 - FRAC_BITS;
  localparam int CW    = 34 - RS;
  localparam int PXW   = 12 + FRAC_BITS;
  // point minus a negative position needs two bits above the wider operand
  localparam int DXW   = ((PXW > POS_W) ? PXW : POS_W) + 2;
  localparam int AXW   = DXW - (FRAC_BITS - 8);
  localparam int ACC_W = 2 * AXW + 1;

  localparam logic signed [63:0] START_FIX_X = 64'(RST_START_X) << FRAC_BITS;
  localparam logic signed [63:0] START_FIX_Y = 64'(RST_START_Y) << FRAC_BITS;
  localparam logic signed [POS_W-1:0] POS_RST_X =
    (START_FIX_X > 64'(POS_MAX)) ? POS_MAX : POS_W'(START_FIX_X);
  localparam logic signed [POS_W-1:0] POS_RST_Y =
    (START_FIX_Y > 64'(POS_MAX)) ? POS_MAX : POS_W'(START_FIX_Y);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(POS_MAX)) return POS_MAX;
    if (v < PROD_W'(POS_MIN)) return POS_MIN;
    return POS_W'(v);
  endfunction

  function automatic logic signed [8:0] clamp_speed(input logic signed [8:0] v,
                                                    input logic [7:0] m);
    logic signed [8:0] lim;
    lim = $signed({1'b0, m});
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // configuration; start position is fixed by the reset defaults
  logic [7:0]  min_speed, max_speed;
  logic [10:0] obstacle_distance;
  logic [23:0] backoff_time;
  logic [15:0] inverse_wheel_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed          <= RST_MIN_SPEED;
      max_speed          <= RST_MAX_SPEED;
      obstacle_distance  <= RST_OBST_DIST;
      backoff_time       <= RST_BACKOFF_TIME;
      inverse_wheel_base <= RST_INV_WBASE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_SPEED:    min_speed          <= cfg_data[7:0];
        CFG_MAX_SPEED:    max_speed          <= cfg_data[7:0];
        CFG_OBST_DIST:    obstacle_distance  <= cfg_data[10:0];
        CFG_BACKOFF_TIME: backoff_time       <= cfg_data;
        CFG_INV_WBASE:    inverse_wheel_base <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic        pv_q, eof_q;
  logic [11:0] px_q, py_q;
  logic [15:0] dt_q;

  // state and working registers
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [15:0]             heading;
  logic signed [24:0]      rem;
  logic                    near, backing_q;
  logic [AXW-1:0]          ax, ay;
  logic [37:0]             thr2;
  logic [ACC_W-1:0]        acc;
  logic signed [8:0]       vl, vr;
  logic signed [9:0]       v2, dvel;
  logic signed [33:0]      cx, cy, cz;
  logic                    flip;
  logic [ITER_W-1:0]       iter;
  logic signed [CW-1:0]    c_q, s_q;
  logic signed [26:0]      vdt, w;
  logic [37:0]             u;
  logic signed [PROD_W-1:0] mx, my;
  logic [55:0]             hacc;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_DIFF: begin
        mul_a = $signed(MUL_W'({obstacle_distance, 8'b0}));
        mul_b = $signed(MUL_W'({obstacle_distance, 8'b0}));
      end
      OP_SQX: begin
        mul_a = $signed(MUL_W'(ax));
        mul_b = $signed(MUL_W'(ax));
      end
      OP_SQY: begin
        mul_a = $signed(MUL_W'(ay));
        mul_b = $signed(MUL_W'(ay));
      end
      OP_VDT: begin
        mul_a = MUL_W'(v2);
        mul_b = $signed(MUL_W'(dt_q));
      end
      OP_WDT: begin
        mul_a = MUL_W'(dvel);
        mul_b = $signed(MUL_W'(dt_q));
      end
      OP_UMUL: begin
        mul_a = $signed(MUL_W'(inverse_wheel_base));
        mul_b = $signed(MUL_W'(BRAD_PER_RAD));
      end
      OP_MX: begin
        mul_a = MUL_W'(vdt);
        mul_b = MUL_W'(c_q);
      end
      OP_MY: begin
        mul_a = MUL_W'(vdt);
        mul_b = MUL_W'(s_q);
      end
      OP_HLO: begin
        mul_a = MUL_W'(w);
        mul_b = $signed(MUL_W'(u[18:0]));
      end
      OP_HHI: begin
        mul_a = MUL_W'(w);
        mul_b = $signed(MUL_W'(u[37:19]));
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // distance to the point, magnitude cut to q.8
  logic signed [DXW-1:0] dx_c, dy_c;
  logic [DXW-1:0]        mag_x, mag_y;

  assign dx_c  = $signed(DXW'({px_q, {FRAC_BITS{1'b0}}})) - DXW'(pos_x);
  assign dy_c  = $signed(DXW'({py_q, {FRAC_BITS{1'b0}}})) - DXW'(pos_y);
  assign mag_x = dx_c[DXW-1] ? DXW'(-dx_c) : DXW'(dx_c);
  assign mag_y = dy_c[DXW-1] ? DXW'(-dy_c) : DXW'(dy_c);

  // manoeuvre choice
  logic              backing_c;
  logic signed [8:0] vl_c, vr_c;
  logic [31:0]       z32, z32f;
  logic              flip_c;

  assign backing_c = near && (rem > 25'sd0);
  assign vr_c = backing_c ? (9'sd0 - $signed({1'b0, min_speed}))
                          : $signed({1'b0, min_speed});
  assign vl_c = backing_c ? (9'sd0 - $signed({2'b0, min_speed[7:1]}))
                          : $signed({1'b0, min_speed});
  assign z32    = {heading, 16'b0};
  assign flip_c = heading[15] ^ heading[14];
  assign z32f   = flip_c ? (z32 ^ 32'h8000_0000) : z32;

  // cordic step
  logic signed [33:0] sh_x, sh_y, atan_c, xf, yf;
  assign sh_x   = cx >>> iter;
  assign sh_y   = cy >>> iter;
  assign atan_c = $signed(34'(ATAN_TURN[iter]));
  assign xf     = flip ? -cx : cx;
  assign yf     = flip ? -cy : cy;

  // pose update
  logic signed [PROD_W-1:0] rx, ry, nx, ny;
  logic [55:0]              hsum;
  logic [15:0]              heading_c;

  assign rx        = (mx + PROD_W'(65536)) >>> 17;
  assign ry        = (my + PROD_W'(65536)) >>> 17;
  assign nx        = PROD_W'(pos_x) + rx;
  assign ny        = PROD_W'(pos_y) - ry;
  assign hsum      = hacc + (56'd1 << 39);
  assign heading_c = heading + hsum[55:40];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_RST_X;
      pos_y     <= POS_RST_Y;
      heading   <= '0;
      rem       <= $signed({1'b0, RST_BACKOFF_TIME});
      near      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_UPD) out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
      unique case (cmd.op)
        OP_DIFF: thr2 <= prod[37:0];
        OP_SQX:  acc  <= ACC_W'(prod);
        OP_SQY:  acc  <= acc + ACC_W'(prod);
        OP_NEAR: if (acc < ACC_W'(thr2)) near <= 1'b1;
        OP_DEC: begin
          backing_q <= backing_c;
          rem       <= backing_c ? (rem - $signed({9'b0, dt_q}))
                                 : $signed({1'b0, backoff_time});
          vl   <= vl_c;
          vr   <= vr_c;
          v2   <= 10'(vl_c) + 10'(vr_c);
          dvel <= 10'(vr_c) - 10'(vl_c);
          near <= 1'b0;
          cx   <= CORDIC_GAIN;
          cy   <= '0;
          cz   <= 34'($signed(z32f));
          flip <= flip_c;
          iter <= '0;
        end
        OP_CORD: begin
          if (!cz[33]) begin
            cx <= cx - sh_y;
            cy <= cy + sh_x;
            cz <= cz - atan_c;
          end else begin
            cx <= cx + sh_y;
            cy <= cy - sh_x;
            cz <= cz + atan_c;
          end
          iter <= iter + 1'b1;
        end
        OP_VDT: begin
          c_q <= CW'((xf + (34'sd1 <<< (RS - 1))) >>> RS);
          s_q <= CW'((yf + (34'sd1 <<< (RS - 1))) >>> RS);
          vdt <= 27'(prod);
        end
        OP_WDT:  w    <= 27'(prod);
        OP_UMUL: u    <= prod[37:0];
        OP_MX:   mx   <= prod;
        OP_MY:   my   <= prod;
        OP_HLO:  hacc <= prod[55:0];
        OP_HHI:  hacc <= hacc + {prod[36:0], 19'b0};
        OP_UPD: begin
          pos_x   <= sat_pos(nx);
          pos_y   <= sat_pos(ny);
          heading <= heading_c;
        end
        default: ;
      endcase
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      pv_q  <= point_valid;
      eof_q <= end_of_frame;
      px_q  <= point_x;
      py_q  <= point_y;
      dt_q  <= step_time;
    end
    if (cmd.op == OP_DIFF) begin
      ax <= mag_x[DXW-1 -: AXW];
      ay <= mag_y[DXW-1 -: AXW];
    end
    if (cmd.op == OP_UPD) begin
      position_x_out  <= sat_pos(nx);
      position_y_out  <= sat_pos(ny);
      heading_out     <= heading_c;
      left_speed_out  <= clamp_speed(vl, max_speed);
      right_speed_out <= clamp_speed(vr, max_speed);
      backing_up      <= backing_q;
      countdown_out   <= rem;
    end
  end

  assign status.point_valid  = pv_q;
  assign status.end_of_frame = eof_q;
  assign status.cordic_last  = (iter == ITER_W'(CORDIC_ITERATIONS - 1));
  assign status.out_full     = out_valid && !out_ready;

endmodule

[rtl/core/diff_drive_obstacle_backoff_core.sv]
// ----------------------------------------------------------------------------
// diff_drive_obstacle_backoff_core
// differential drive robot with obstacle backoff, fixed point pose tracking
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one beat per obstacle point or frame
//   end; the beat with end_of_frame runs a control and kinematics step and
//   produces exactly one result beat on the output channel
//   config channel (cfg_valid/cfg_ready): always ready, write only while idle
// timing
//   a beat without a point occupies the core for the load and point check,
//   one with a point also for the distance squares on the shared multiplier;
//   a frame end adds the one-iteration-per-cycle cordic and seven
//   multiplier passes; its result is valid right after the update
//   in_ready is high only while the sequencer waits for a beat
// reset
//   synchronous rst restores register defaults and the start pose, heading
//   zero, countdown at its reload value
// stall
//   the result is held in an output register; a new beat is accepted while
//   it waits, and only the next frame end stalls until it has been taken
// ----------------------------------------------------------------------------
module diff_drive_obstacle_backoff_core import ddob_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS         = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  // input beats
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    point_valid,
  input  logic [11:0]             point_x,
  input  logic [11:0]             point_y,
  input  logic                    end_of_frame,
  input  logic [15:0]             step_time,
  // result beats
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] position_x_out,
  output logic signed [POS_W-1:0] position_y_out,
  output logic [15:0]             heading_out,
  output logic signed [8:0]       left_speed_out,
  output logic signed [8:0]       right_speed_out,
  output logic                    backing_up,
  output logic signed [24:0]      countdown_out
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequencer
  ddob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, pose state and result register
  ddob_datapath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .FRAC_BITS         (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .point_valid     (point_valid),
    .point_x         (point_x),
    .point_y         (point_y),
    .end_of_frame    (end_of_frame),
    .step_time       (step_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .position_x_out  (position_x_out),
    .position_y_out  (position_y_out),
    .heading_out     (heading_out),
    .left_speed_out  (left_speed_out),
    .right_speed_out (right_speed_out),
    .backing_up      (backing_up),
    .countdown_out   (countdown_out)
  );

  // a capture happens only on an accepted beat
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> (in_valid && in_ready))
    else $error("capture without an accepted input beat");

  // an accepted beat drops in_ready, so no beat is accepted directly after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_UPD) |-> !(out_valid && !out_ready))
    else $error("result register overwritten while stalled");

  // a result appears only after a pose update
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_UPD))
    else $error("result valid without a pose update");

endmodule
